FILE: design/fixed_wing_autopilot_pid_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-wing autopilot
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_WING_AUTOPILOT_PID_ASSERT_SVH
`define FIXED_WING_AUTOPILOT_PID_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define FWAP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FWAP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fwap_pkg.sv
// ----------------------------------------------------------------------------
// Autopilot package
// Widths, gains, register map, microcode format and program, and clamps.
// ----------------------------------------------------------------------------
`default_nettype none

package fwap_pkg;

    localparam int A_W     = 35;
    localparam int B_W     = 18;
    localparam int PROD_W  = 53;
    localparam int ACC_W   = 54;
    localparam int RND_W   = ACC_W - 16;
    localparam int PCMD_W  = 33;
    localparam int INTEG_W = 48;
    localparam int STEP_W  = 5;
    localparam int PADDR_W = 5;

    localparam logic signed [B_W-1:0] K_HALF   = 18'sd32768;
    localparam logic signed [B_W-1:0] K_CLIMB  = 18'sd13107;
    localparam logic signed [B_W-1:0] K_ELE_P  = -18'sd52429;
    localparam logic signed [B_W-1:0] K_ELE_D  = 18'sd5898;
    localparam logic signed [B_W-1:0] K_AIL_D  = -18'sd3277;
    localparam logic signed [B_W-1:0] K_RUD    = -18'sd13107;
    localparam logic signed [B_W-1:0] K_THR_P  = 18'sd75;
    localparam logic signed [B_W-1:0] K_UNIT16 = 18'sd65536;

    localparam logic signed [ACC_W-1:0] RND_HALF = 54'sd32768;
    localparam logic [27:0] THR_FULL = 28'd196608000;
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    localparam logic signed [31:0] ALT_T_RST = 32'shFF920000;
    localparam logic [22:0] SPD_T_RST = 23'd786432;
    localparam logic [17:0] LIM_RST   = 18'd34315;
    localparam logic [27:0] BIAS_RST  = 28'd65536000;

    localparam logic [STEP_W-1:0] STEP_ZERO   = 5'd0;
    localparam logic [STEP_W-1:0] STEP_NOHOLD = 5'd16;

    typedef enum logic [2:0] {
        REG_ALT_T, REG_SPD_T, REG_HOLD, REG_ROLL_T,
        REG_ELE_LIM, REG_AIL_LIM, REG_RUD_LIM, REG_BIAS
    } t_reg;

    typedef enum logic [3:0] {
        A_ALT_ERR, A_CLIMB, A_PCMD_ERR, A_PITCH_Q, A_ROLL_ERR,
        A_ROLL_P, A_ROLL_T, A_SPD_ERR, A_SPD_ERR2, A_BIAS
    } t_asel;

    typedef enum logic [3:0] {
        B_HALF, B_CLIMB, B_ELE_P, B_ELE_D, B_AIL_D, B_RUD, B_THR_P, B_UNIT16, B_DT
    } t_bsel;

    typedef enum logic [2:0] {
        ACC_HOLD, ACC_LOAD_RND, ACC_LOAD_SHL_RND, ACC_ADD, ACC_INTEG_ADD, ACC_ADD_INTEG
    } t_accop;

    typedef enum logic [2:0] {
        DST_NONE, DST_PCMD, DST_ELE, DST_AIL, DST_RUD, DST_INTEG, DST_THR, DST_THR_FULL
    } t_dst;

    typedef enum logic [1:0] {
        JMP_NEXT, JMP_NOHOLD, JMP_DONE
    } t_jmp;

    typedef struct packed {
        t_asel               asel;
        t_bsel               bsel;
        t_accop              acc;
        t_dst                dst;
        t_jmp                jmp;
        logic [STEP_W-1:0]   target;
    } t_uword;

    // Each word issues one product and consumes the one issued the step before.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            5'd0:  w = '{A_ALT_ERR,  B_HALF,   ACC_HOLD,         DST_NONE,     JMP_NEXT,   STEP_ZERO};
            5'd1:  w = '{A_CLIMB,    B_CLIMB,  ACC_LOAD_RND,     DST_NONE,     JMP_NEXT,   STEP_ZERO};
            5'd2:  w = '{A_ALT_ERR,  B_HALF,   ACC_ADD,          DST_NONE,     JMP_NEXT,   STEP_ZERO};
            5'd3:  w = '{A_ALT_ERR,  B_HALF,   ACC_HOLD,         DST_PCMD,     JMP_NEXT,   STEP_ZERO};
            5'd4:  w = '{A_PCMD_ERR, B_ELE_P,  ACC_HOLD,         DST_NONE,     JMP_NEXT,   STEP_ZERO};
            5'd5:  w = '{A_PITCH_Q,  B_ELE_D,  ACC_LOAD_RND,     DST_NONE,     JMP_NEXT,   STEP_ZERO};
            5'd6:  w = '{A_ROLL_ERR, B_HALF,   ACC_ADD,          DST_NONE,     JMP_NEXT,   STEP_ZERO};
            5'd7:  w = '{A_ROLL_P,   B_AIL_D,  ACC_LOAD_RND,     DST_ELE,      JMP_NEXT,   STEP_ZERO};
            5'd8:  w = '{A_ROLL_T,   B_RUD,    ACC_ADD,          DST_NONE,     JMP_NEXT,   STEP_ZERO};
            5'd9:  w = '{A_SPD_ERR2, B_DT,     ACC_LOAD_RND,     DST_AIL,      JMP_NEXT,   STEP_ZERO};
            5'd10: w = '{A_ALT_ERR,  B_HALF,   ACC_INTEG_ADD,    DST_RUD,      JMP_NOHOLD, STEP_NOHOLD};
            5'd11: w = '{A_SPD_ERR,  B_THR_P,  ACC_HOLD,         DST_INTEG,    JMP_NEXT,   STEP_ZERO};
            5'd12: w = '{A_BIAS,     B_UNIT16, ACC_LOAD_SHL_RND, DST_NONE,     JMP_NEXT,   STEP_ZERO};
            5'd13: w = '{A_ALT_ERR,  B_HALF,   ACC_ADD,          DST_NONE,     JMP_NEXT,   STEP_ZERO};
            5'd14: w = '{A_ALT_ERR,  B_HALF,   ACC_ADD_INTEG,    DST_NONE,     JMP_NEXT,   STEP_ZERO};
            5'd15: w = '{A_ALT_ERR,  B_HALF,   ACC_HOLD,         DST_THR,      JMP_DONE,   STEP_ZERO};
            5'd16: w = '{A_ALT_ERR,  B_HALF,   ACC_HOLD,         DST_THR_FULL, JMP_DONE,   STEP_ZERO};
            default: w = '{A_ALT_ERR, B_HALF,  ACC_HOLD,         DST_NONE,     JMP_DONE,   STEP_ZERO};
        endcase
        return w;
    endfunction

    function automatic logic signed [18:0] clamp_sym(input logic signed [RND_W-1:0] v,
                                                     input logic [17:0] lim);
        logic signed [RND_W-1:0] hi;
        logic signed [RND_W-1:0] lo;
        hi = RND_W'($signed({1'b0, lim}));
        lo = -hi;
        if (v > hi) begin
            return hi[18:0];
        end else if (v < lo) begin
            return lo[18:0];
        end
        return v[18:0];
    endfunction

    function automatic logic [27:0] clamp_thr(input logic signed [RND_W-1:0] v);
        logic signed [RND_W-1:0] full;
        full = $signed(RND_W'(THR_FULL));
        if (v < 0) begin
            return '0;
        end else if (v > full) begin
            return THR_FULL;
        end
        return v[27:0];
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(INTEG_MAX)) begin
            return INTEG_MAX;
        end else if (v < ACC_W'(INTEG_MIN)) begin
            return INTEG_MIN;
        end
        return v[INTEG_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/fwap_in_if.sv
// ----------------------------------------------------------------------------
// Measurement channel
// Valid/ready channel carrying one set of aircraft measurements per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwap_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] altitude;
    logic signed [31:0] climb_rate;
    logic signed [18:0] roll_angle;
    logic signed [18:0] pitch_angle;
    logic signed [23:0] forward_speed;
    logic signed [31:0] roll_rate;
    logic signed [31:0] pitch_rate;
    logic        [16:0] time_step;

    modport source (
        output valid, altitude, climb_rate, roll_angle, pitch_angle,
               forward_speed, roll_rate, pitch_rate, time_step,
        input  ready
    );
    modport sink (
        input  valid, altitude, climb_rate, roll_angle, pitch_angle,
               forward_speed, roll_rate, pitch_rate, time_step,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/fwap_out_if.sv
// ----------------------------------------------------------------------------
// Actuator command channel
// Valid/ready channel carrying one set of surface and throttle commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwap_out_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] elevator;
    logic signed [18:0] aileron;
    logic signed [18:0] rudder;
    logic        [27:0] throttle;

    modport source (
        output valid, elevator, aileron, rudder, throttle,
        input  ready
    );
    modport sink (
        input  valid, elevator, aileron, rudder, throttle,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/fixed_wing_autopilot_pid.sv
// ----------------------------------------------------------------------------
// Fixed-wing autopilot
// Cascaded altitude/pitch, roll and speed laws run by a microcoded sequencer
// over one shared multiplier and one accumulator.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake            Content
//  i_item    in   valid/ready          measurements, one item
//  o_result  out  valid/ready          surface and throttle commands
//  apb       in   psel/penable/pwrite  eight configuration registers
//
// With speed hold disabled the program skips the speed law and commands full
// throttle; it issues one product per step on the multiplier.
// A new item is taken in the last step of the previous one.
// The last step waits while an earlier result has not been taken.
// Synchronous active-low reset loads the register defaults and clears the
// integrator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_wing_autopilot_pid_assert.svh"

module fixed_wing_autopilot_pid (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    fwap_in_if.sink                            i_item,
    fwap_out_if.source                         o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fwap_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    typedef enum logic {S_IDLE, S_RUN} t_seq;

    t_seq                                   r_state;
    logic [fwap_pkg::STEP_W-1:0]            r_step;
    logic                                   r_out_vld;
    logic signed [18:0]                     r_out_ele;
    logic signed [18:0]                     r_out_ail;
    logic signed [18:0]                     r_out_rud;
    logic [27:0]                            r_out_thr;

    logic signed [31:0]                     r_alt_t;
    logic [22:0]                            r_spd_t;
    logic                                   r_hold;
    logic signed [18:0]                     r_roll_t;
    logic [17:0]                            r_ele_lim;
    logic [17:0]                            r_ail_lim;
    logic [17:0]                            r_rud_lim;
    logic [27:0]                            r_bias;

    logic signed [31:0]                     r_alt;
    logic signed [31:0]                     r_climb;
    logic signed [18:0]                     r_roll;
    logic signed [18:0]                     r_pitch;
    logic signed [23:0]                     r_speed;
    logic signed [31:0]                     r_p;
    logic signed [31:0]                     r_q;
    logic [16:0]                            r_dt;

    logic signed [fwap_pkg::PROD_W-1:0]     r_prod;
    logic signed [fwap_pkg::ACC_W-1:0]      r_acc;
    logic signed [fwap_pkg::PCMD_W-1:0]     r_pcmd;
    logic signed [18:0]                     r_ele;
    logic signed [18:0]                     r_ail;
    logic signed [18:0]                     r_rud;
    logic signed [fwap_pkg::INTEG_W-1:0]    r_integ;

    fwap_pkg::t_uword                       uw;
    logic                                   run;
    logic                                   done_word;
    logic                                   out_full;
    logic                                   step_go;
    logic                                   last_go;
    logic                                   in_acc;
    logic                                   cfg_wr;
    logic [fwap_pkg::STEP_W-1:0]            n_step;
    logic signed [fwap_pkg::A_W-1:0]        a_op;
    logic signed [fwap_pkg::B_W-1:0]        b_op;
    logic signed [fwap_pkg::RND_W-1:0]      rnd;
    logic [27:0]                            thr_val;
    logic signed [24:0]                     spd_err;

    assign uw        = fwap_pkg::ucode(r_step);
    assign run       = (r_state == S_RUN);
    assign done_word = (uw.jmp == fwap_pkg::JMP_DONE);
    assign out_full  = r_out_vld && !o_result.ready;
    assign step_go   = run && !(done_word && out_full);
    assign last_go   = step_go && done_word;
    assign in_acc    = i_item.valid && i_item.ready;
    assign cfg_wr    = psel && penable && pwrite && pready;

    assign i_item.ready     = (r_state == S_IDLE) || last_go;
    assign o_result.valid    = r_out_vld;
    assign o_result.elevator = r_out_ele;
    assign o_result.aileron  = r_out_ail;
    assign o_result.rudder   = r_out_rud;
    assign o_result.throttle = r_out_thr;
    assign pready            = 1'b1;

    always_comb begin
        if (uw.jmp == fwap_pkg::JMP_NOHOLD && !r_hold) begin
            n_step = uw.target;
        end else begin
            n_step = r_step + 5'd1;
        end
    end

    assign spd_err = 25'($signed({1'b0, r_spd_t})) - 25'(r_speed);
    assign rnd     = r_acc[fwap_pkg::ACC_W-1:16];
    assign thr_val = (uw.dst == fwap_pkg::DST_THR_FULL) ? fwap_pkg::THR_FULL
                                                        : fwap_pkg::clamp_thr(rnd);

    always_comb begin
        case (uw.asel)
            fwap_pkg::A_ALT_ERR:  a_op = fwap_pkg::A_W'(33'(r_alt) - 33'(r_alt_t));
            fwap_pkg::A_CLIMB:    a_op = fwap_pkg::A_W'(r_climb);
            fwap_pkg::A_PCMD_ERR: a_op = fwap_pkg::A_W'(34'(r_pcmd) - 34'(r_pitch));
            fwap_pkg::A_PITCH_Q:  a_op = fwap_pkg::A_W'(r_q);
            fwap_pkg::A_ROLL_ERR: a_op = fwap_pkg::A_W'(20'(r_roll_t) - 20'(r_roll));
            fwap_pkg::A_ROLL_P:   a_op = fwap_pkg::A_W'(r_p);
            fwap_pkg::A_ROLL_T:   a_op = fwap_pkg::A_W'(r_roll_t);
            fwap_pkg::A_SPD_ERR:  a_op = fwap_pkg::A_W'(spd_err);
            fwap_pkg::A_SPD_ERR2: a_op = fwap_pkg::A_W'($signed({spd_err, 1'b0}));
            fwap_pkg::A_BIAS:     a_op = fwap_pkg::A_W'($signed({1'b0, r_bias}));
            default:              a_op = '0;
        endcase
    end

    always_comb begin
        case (uw.bsel)
            fwap_pkg::B_HALF:   b_op = fwap_pkg::K_HALF;
            fwap_pkg::B_CLIMB:  b_op = fwap_pkg::K_CLIMB;
            fwap_pkg::B_ELE_P:  b_op = fwap_pkg::K_ELE_P;
            fwap_pkg::B_ELE_D:  b_op = fwap_pkg::K_ELE_D;
            fwap_pkg::B_AIL_D:  b_op = fwap_pkg::K_AIL_D;
            fwap_pkg::B_RUD:    b_op = fwap_pkg::K_RUD;
            fwap_pkg::B_THR_P:  b_op = fwap_pkg::K_THR_P;
            fwap_pkg::B_UNIT16: b_op = fwap_pkg::K_UNIT16;
            fwap_pkg::B_DT:     b_op = $signed({1'b0, r_dt});
            default:            b_op = '0;
        endcase
    end

    always_comb begin
        case (fwap_pkg::t_reg'(paddr[4:2]))
            fwap_pkg::REG_ALT_T:   prdata = r_alt_t;
            fwap_pkg::REG_SPD_T:   prdata = {9'd0, r_spd_t};
            fwap_pkg::REG_HOLD:    prdata = {31'd0, r_hold};
            fwap_pkg::REG_ROLL_T:  prdata = {13'd0, r_roll_t};
            fwap_pkg::REG_ELE_LIM: prdata = {14'd0, r_ele_lim};
            fwap_pkg::REG_AIL_LIM: prdata = {14'd0, r_ail_lim};
            fwap_pkg::REG_RUD_LIM: prdata = {14'd0, r_rud_lim};
            fwap_pkg::REG_BIAS:    prdata = {4'd0, r_bias};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_t   <= fwap_pkg::ALT_T_RST;
            r_spd_t   <= fwap_pkg::SPD_T_RST;
            r_hold    <= 1'b1;
            r_roll_t  <= '0;
            r_ele_lim <= fwap_pkg::LIM_RST;
            r_ail_lim <= fwap_pkg::LIM_RST;
            r_rud_lim <= fwap_pkg::LIM_RST;
            r_bias    <= fwap_pkg::BIAS_RST;
        end else if (cfg_wr) begin
            case (fwap_pkg::t_reg'(paddr[4:2]))
                fwap_pkg::REG_ALT_T:   r_alt_t   <= pwdata;
                fwap_pkg::REG_SPD_T:   r_spd_t   <= pwdata[22:0];
                fwap_pkg::REG_HOLD:    r_hold    <= pwdata[0];
                fwap_pkg::REG_ROLL_T:  r_roll_t  <= pwdata[18:0];
                fwap_pkg::REG_ELE_LIM: r_ele_lim <= pwdata[17:0];
                fwap_pkg::REG_AIL_LIM: r_ail_lim <= pwdata[17:0];
                fwap_pkg::REG_RUD_LIM: r_rud_lim <= pwdata[17:0];
                fwap_pkg::REG_BIAS:    r_bias    <= pwdata[27:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_alt   <= i_item.altitude;
            r_climb <= i_item.climb_rate;
            r_roll  <= i_item.roll_angle;
            r_pitch <= i_item.pitch_angle;
            r_speed <= i_item.forward_speed;
            r_p     <= i_item.roll_rate;
            r_q     <= i_item.pitch_rate;
            r_dt    <= i_item.time_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_prod <= a_op * b_op;
            case (uw.acc)
                fwap_pkg::ACC_LOAD_RND:
                    r_acc <= fwap_pkg::ACC_W'(r_prod) + fwap_pkg::RND_HALF;
                fwap_pkg::ACC_LOAD_SHL_RND:
                    r_acc <= $signed({r_prod[fwap_pkg::ACC_W-17:0], 16'd0})
                             + fwap_pkg::RND_HALF;
                fwap_pkg::ACC_ADD:
                    r_acc <= r_acc + fwap_pkg::ACC_W'(r_prod);
                fwap_pkg::ACC_INTEG_ADD:
                    r_acc <= fwap_pkg::ACC_W'(r_integ) + fwap_pkg::ACC_W'(r_prod);
                fwap_pkg::ACC_ADD_INTEG:
                    r_acc <= r_acc + fwap_pkg::ACC_W'(r_integ);
                default: begin
                end
            endcase
            case (uw.dst)
                fwap_pkg::DST_PCMD: r_pcmd <= rnd[fwap_pkg::PCMD_W-1:0];
                fwap_pkg::DST_ELE:  r_ele  <= fwap_pkg::clamp_sym(rnd, r_ele_lim);
                fwap_pkg::DST_AIL:  r_ail  <= fwap_pkg::clamp_sym(rnd, r_ail_lim);
                fwap_pkg::DST_RUD:  r_rud  <= fwap_pkg::clamp_sym(rnd, r_rud_lim);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (step_go && uw.dst == fwap_pkg::DST_INTEG) begin
            r_integ <= fwap_pkg::sat_integ(r_acc);
        end else if (step_go && uw.dst == fwap_pkg::DST_THR_FULL) begin
            r_integ <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= fwap_pkg::STEP_ZERO;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state <= S_RUN;
                r_step  <= fwap_pkg::STEP_ZERO;
            end else if (last_go) begin
                r_state <= S_IDLE;
            end else if (step_go) begin
                r_step <= n_step;
            end
            if (last_go) begin
                r_out_vld <= 1'b1;
                r_out_ele <= r_ele;
                r_out_ail <= r_ail;
                r_out_rud <= r_rud;
                r_out_thr <= thr_val;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    `FWAP_ASSERT_NXT(a_stall_holds_step, run && done_word && out_full, $stable(r_step) && run, "sequencer moved while the result was blocked")
    `FWAP_ASSERT_NXT(a_done_gives_result, last_go, r_out_vld, "finished item produced no result")
    `FWAP_ASSERT_NXT(a_hold_off_clears, last_go && !r_hold, r_integ == '0, "integrator not cleared with speed hold off")
    `FWAP_ASSERT_IMP(a_thr_range, r_out_vld, r_out_thr <= fwap_pkg::THR_FULL, "throttle above full scale")

endmodule

`default_nettype wire
